// ===== src/fmwl_pkg.sv =====
// Shared constants, types and codes of the field-map window lookup block.
package fmwl_pkg;

	localparam int TABLE_DEPTH = 8192;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int POS_W = 20;
	localparam int FLD_W = 21;
	localparam int SLOT_W = 13;
	localparam int TOL_W = 19;
	localparam int ECNT_W = 14;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE = 3'd0,
		REG_ENTRY_COUNT = 3'd1,
		REG_BOX_MIN_X = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MIN_Y = 3'd4,
		REG_BOX_MAX_Y = 3'd5,
		REG_BOX_MIN_Z = 3'd6,
		REG_BOX_MAX_Z = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	// Input transfer payload, last declared field in the lowest bits.
	typedef struct packed {
		logic signed [FLD_W-1:0] load_bz;
		logic signed [FLD_W-1:0] load_by;
		logic signed [FLD_W-1:0] load_bx;
		logic signed [POS_W-1:0] coord_z;
		logic signed [POS_W-1:0] coord_y;
		logic signed [POS_W-1:0] coord_x;
		logic [SLOT_W-1:0] entry_index;
	} in_data_t;

	// Output transfer payload, padded to whole bytes.
	typedef struct packed {
		logic [3:0] pad;
		logic [SLOT_W-1:0] match_slot;
		logic signed [FLD_W-1:0] field_z;
		logic signed [FLD_W-1:0] field_y;
		logic signed [FLD_W-1:0] field_x;
	} out_data_t;

	// One table entry as stored in the RAM.
	typedef struct packed {
		logic signed [FLD_W-1:0] fz;
		logic signed [FLD_W-1:0] fy;
		logic signed [FLD_W-1:0] fx;
		logic signed [POS_W-1:0] pz;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] px;
	} entry_t;

	typedef struct packed {
		logic load_we;
		logic start;
		logic issue;
		logic capture;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic in_box;
		logic lim_zero;
		logic issue_done;
		logic pend;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

// ===== src/fmwl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fmwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/fmwl_ctrl.sv =====
// Controller state machine: sequences loads, table scans and result hand-off.
module fmwl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tuser,
	output logic            s_tready,
	input  fmwl_pkg::sts_t  sts,
	output fmwl_pkg::cmd_t  cmd
);

	fmwl_pkg::state_t state_q, state_nxt;
	fmwl_pkg::op_t op;

	assign op = fmwl_pkg::op_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmwl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fmwl_pkg::ST_IDLE: begin
				if (s_tvalid && op == fmwl_pkg::OP_QUERY) begin
					state_nxt = (sts.in_box && !sts.lim_zero) ? fmwl_pkg::ST_SCAN
						: fmwl_pkg::ST_RESULT;
				end
			end
			fmwl_pkg::ST_SCAN: begin
				if (sts.hit || (sts.issue_done && !sts.pend)) begin
					state_nxt = fmwl_pkg::ST_RESULT;
				end
			end
			fmwl_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					state_nxt = fmwl_pkg::ST_IDLE;
				end
			end
			default: state_nxt = fmwl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd = '0;
		unique case (state_q)
			fmwl_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load_we = s_tvalid && op == fmwl_pkg::OP_LOAD;
				cmd.start = s_tvalid && op == fmwl_pkg::OP_QUERY;
			end
			fmwl_pkg::ST_SCAN: begin
				cmd.issue = !sts.issue_done && !sts.hit;
				cmd.capture = sts.hit;
			end
			fmwl_pkg::ST_RESULT: begin
				cmd.push = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// A query outside the box or with nothing to scan goes straight to the result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fmwl_pkg::ST_IDLE && cmd.start && (!sts.in_box || sts.lim_zero))
		|=> state_q == fmwl_pkg::ST_RESULT)
		else $error("query without scan did not go to result");

	// The scan never leaves with a read still in flight unless it hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fmwl_pkg::ST_SCAN && state_nxt == fmwl_pkg::ST_RESULT)
		|-> (sts.hit || !sts.pend))
		else $error("scan ended with a pending read");

	// A new item is only taken while no query is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_we || cmd.start) |-> $past(state_nxt) == fmwl_pkg::ST_IDLE)
		else $error("item accepted during a query");

endmodule

// ===== src/fmwl_dp.sv =====
// Datapath: configuration registers, table RAM, scan counter, match logic, output register.
module fmwl_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fmwl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fmwl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [135:0]                        s_tdata,
	output logic [79:0]                         m_tdata,
	output logic                                m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  fmwl_pkg::cmd_t                      cmd,
	output fmwl_pkg::sts_t                      sts
);

	fmwl_pkg::in_data_t in_d;
	fmwl_pkg::entry_t   wr_entry, rd_entry;

	logic [fmwl_pkg::TOL_W-1:0]           tol_q;
	logic [fmwl_pkg::ECNT_W-1:0]          ecnt_q;
	logic signed [fmwl_pkg::POS_W-1:0]    min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [fmwl_pkg::POS_W-1:0]    min_z_q, max_z_q;

	logic signed [fmwl_pkg::POS_W-1:0]    pt_x_q, pt_y_q, pt_z_q;
	logic [fmwl_pkg::CNT_W-1:0]           lim_q, lim_nxt, cnt_q;
	logic                                 valid_s1;
	logic [fmwl_pkg::ADDR_W-1:0]          slot_s1;

	logic signed [fmwl_pkg::FLD_W-1:0]    res_x_q, res_y_q, res_z_q;
	logic [fmwl_pkg::SLOT_W-1:0]          res_slot_q;
	logic                                 res_found_q;

	logic                                 m_tvalid_q;
	fmwl_pkg::out_data_t                  out_q;
	logic                                 out_found_q;

	logic                                 ram_we, match;
	logic [fmwl_pkg::FLD_W-1:0]           ad_x, ad_y, ad_z, tol_ext;
	logic signed [fmwl_pkg::FLD_W-1:0]    neg_fx;

	function automatic logic [fmwl_pkg::FLD_W-1:0] abs_diff(
		input logic signed [fmwl_pkg::POS_W-1:0] a,
		input logic signed [fmwl_pkg::POS_W-1:0] b
	);
		logic [fmwl_pkg::FLD_W-1:0] d;
		d = {a[fmwl_pkg::POS_W-1], a} - {b[fmwl_pkg::POS_W-1], b};
		return d[fmwl_pkg::FLD_W-1] ? (~d + fmwl_pkg::FLD_W'(1)) : d;
	endfunction

	assign in_d = fmwl_pkg::in_data_t'(s_tdata);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= fmwl_pkg::TOL_W'(112);
			ecnt_q  <= '0;
			min_x_q <= {1'b1, {(fmwl_pkg::POS_W-1){1'b0}}};
			max_x_q <= {1'b0, {(fmwl_pkg::POS_W-1){1'b1}}};
			min_y_q <= {1'b1, {(fmwl_pkg::POS_W-1){1'b0}}};
			max_y_q <= {1'b0, {(fmwl_pkg::POS_W-1){1'b1}}};
			min_z_q <= {1'b1, {(fmwl_pkg::POS_W-1){1'b0}}};
			max_z_q <= {1'b0, {(fmwl_pkg::POS_W-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (fmwl_pkg::cfg_reg_t'(cfg_index))
				fmwl_pkg::REG_TOLERANCE:   tol_q   <= cfg_data[fmwl_pkg::TOL_W-1:0];
				fmwl_pkg::REG_ENTRY_COUNT: ecnt_q  <= cfg_data[fmwl_pkg::ECNT_W-1:0];
				fmwl_pkg::REG_BOX_MIN_X:   min_x_q <= cfg_data;
				fmwl_pkg::REG_BOX_MAX_X:   max_x_q <= cfg_data;
				fmwl_pkg::REG_BOX_MIN_Y:   min_y_q <= cfg_data;
				fmwl_pkg::REG_BOX_MAX_Y:   max_y_q <= cfg_data;
				fmwl_pkg::REG_BOX_MIN_Z:   min_z_q <= cfg_data;
				fmwl_pkg::REG_BOX_MAX_Z:   max_z_q <= cfg_data;
				default:                   tol_q   <= tol_q;
			endcase
		end
	end

	// Table RAM: loads write at the transfer, the scan reads one entry per cycle.
	assign ram_we = cmd.load_we && (32'(in_d.entry_index) < fmwl_pkg::TABLE_DEPTH);
	assign wr_entry = '{fz: in_d.load_bz, fy: in_d.load_by, fx: in_d.load_bx,
		pz: in_d.coord_z, py: in_d.coord_y, px: in_d.coord_x};

	fmwl_ram #(
		.WIDTH($bits(fmwl_pkg::entry_t)),
		.DEPTH(fmwl_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fmwl_pkg::ADDR_W'(in_d.entry_index)),
		.wdata (wr_entry),
		.re    (cmd.issue),
		.raddr (cnt_q[fmwl_pkg::ADDR_W-1:0]),
		.rdata (rd_entry)
	);

	// Scan length is the entry count clamped to the table depth.
	always_comb begin
		if (32'(ecnt_q) > fmwl_pkg::TABLE_DEPTH) begin
			lim_nxt = fmwl_pkg::CNT_W'(fmwl_pkg::TABLE_DEPTH);
		end else begin
			lim_nxt = fmwl_pkg::CNT_W'(ecnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			lim_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.start) begin
				cnt_q <= '0;
				lim_q <= lim_nxt;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + fmwl_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pt_x_q <= in_d.coord_x;
			pt_y_q <= in_d.coord_y;
			pt_z_q <= in_d.coord_z;
		end
		if (cmd.issue) begin
			slot_s1 <= cnt_q[fmwl_pkg::ADDR_W-1:0];
		end
	end

	// Per-axis window test on the entry read out last cycle.
	assign tol_ext = fmwl_pkg::FLD_W'(tol_q);
	assign ad_x = abs_diff(pt_x_q, rd_entry.px);
	assign ad_y = abs_diff(pt_y_q, rd_entry.py);
	assign ad_z = abs_diff(pt_z_q, rd_entry.pz);
	assign match = (ad_x < tol_ext) && (ad_y < tol_ext) && (ad_z < tol_ext);

	// The most negative field has no positive twin and saturates.
	assign neg_fx = (rd_entry.fx == {1'b1, {(fmwl_pkg::FLD_W-1){1'b0}}})
		? {1'b0, {(fmwl_pkg::FLD_W-1){1'b1}}} : -rd_entry.fx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_found_q <= 1'b0;
		end else if (cmd.start) begin
			res_found_q <= 1'b0;
		end else if (cmd.capture) begin
			res_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_x_q    <= '0;
			res_y_q    <= '0;
			res_z_q    <= '0;
			res_slot_q <= '0;
		end else if (cmd.capture) begin
			res_x_q    <= neg_fx;
			res_y_q    <= rd_entry.fy;
			res_z_q    <= rd_entry.fz;
			res_slot_q <= fmwl_pkg::SLOT_W'(slot_s1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q <= '{pad: 4'd0, match_slot: res_slot_q, field_z: res_z_q,
				field_y: res_y_q, field_x: res_x_q};
			out_found_q <= res_found_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_found_q;

	assign sts.in_box = (in_d.coord_x >= min_x_q) && (in_d.coord_x <= max_x_q)
		&& (in_d.coord_y >= min_y_q) && (in_d.coord_y <= max_y_q)
		&& (in_d.coord_z >= min_z_q) && (in_d.coord_z <= max_z_q);
	assign sts.lim_zero   = (lim_nxt == '0);
	assign sts.issue_done = (cnt_q == lim_q);
	assign sts.pend       = valid_s1;
	assign sts.hit        = valid_s1 && match;
	assign sts.out_free   = !m_tvalid_q || m_tready;

	// The scan counter never runs past the clamped entry count.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lim_q)
		else $error("scan counter beyond limit");

	// Every entry that reaches the compare stage lies inside the scanned range.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> fmwl_pkg::CNT_W'(slot_s1) < lim_q)
		else $error("compared entry outside scanned range");

	// A result is only loaded into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a pending transfer");

endmodule

// ===== src/field_map_window_lookup.sv =====
// Top level of the field-map window lookup engine.
//
// The block holds a table of TABLE_DEPTH mesh entries (position and field vector)
// in one single-port-write, registered-read RAM. An input transfer with tuser low
// loads one entry at entry_index and produces no result. An input
// transfer with tuser high queries a point: if the point lies inside the inclusive
// bounding box, the entries 0 .. entry_count-1 (clamped to TABLE_DEPTH) are read one
// per cycle through the RAM read port and the first entry whose per-axis distance
// is below the tolerance supplies the result, with its x field negated and
// saturated. Otherwise a zero field with found low is returned. A query that
// hits entry i stops scanning there, a miss scans all n clamped entries, and a
// point outside the box or a query with nothing to scan skips the scan. Input
// is taken only between queries, while a finished result may still wait in the
// output register. The table RAM is not cleared after reset: every entry must be
// loaded before a query can scan it. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
module field_map_window_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [fmwl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fmwl_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata from bit 0: entry_index[13], coord_x[20], coord_y[20], coord_z[20],
	// load_bx[21], load_by[21], load_bz[21].
	input  logic [135:0]                        s_tdata,
	// s_tuser: opcode (0 load entry, 1 query point).
	input  logic                                s_tuser,
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata from bit 0: field_x[21], field_y[21], field_z[21], match_slot[13], zero pad[4].
	output logic [79:0]                         m_tdata,
	// m_tuser: found.
	output logic                                m_tuser
);

	fmwl_pkg::cmd_t cmd;
	fmwl_pkg::sts_t sts;

	// The controller decides when to take a transfer, step the scan and hand off a result.
	fmwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the registers, the table and the output stage.
	fmwl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the field-map window lookup engine.
module testbench;

	localparam int COORD_MIN = -(1 << (fmwl_pkg::POS_W - 1));
	localparam int COORD_MAX = (1 << (fmwl_pkg::POS_W - 1)) - 1;
	localparam int FIELD_MIN = -(1 << (fmwl_pkg::FLD_W - 1));
	localparam int FIELD_MAX = (1 << (fmwl_pkg::FLD_W - 1)) - 1;
	localparam int TOL_MAX = (1 << fmwl_pkg::TOL_W) - 1;
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_CYCLES = 20;

	// One predicted lookup answer.
	typedef struct packed {
		logic signed [fmwl_pkg::FLD_W-1:0] fx;
		logic signed [fmwl_pkg::FLD_W-1:0] fy;
		logic signed [fmwl_pkg::FLD_W-1:0] fz;
		logic found;
		logic [fmwl_pkg::SLOT_W-1:0] slot;
	} field_result_t;

	// Mirrors the table and registers of the block and checks each returned field
	// against the oldest outstanding query.
	class field_lookup_scoreboard;
		logic signed [fmwl_pkg::POS_W-1:0] pos_x[fmwl_pkg::TABLE_DEPTH];
		logic signed [fmwl_pkg::POS_W-1:0] pos_y[fmwl_pkg::TABLE_DEPTH];
		logic signed [fmwl_pkg::POS_W-1:0] pos_z[fmwl_pkg::TABLE_DEPTH];
		logic signed [fmwl_pkg::FLD_W-1:0] fld_x[fmwl_pkg::TABLE_DEPTH];
		logic signed [fmwl_pkg::FLD_W-1:0] fld_y[fmwl_pkg::TABLE_DEPTH];
		logic signed [fmwl_pkg::FLD_W-1:0] fld_z[fmwl_pkg::TABLE_DEPTH];
		bit loaded[fmwl_pkg::TABLE_DEPTH];
		logic [fmwl_pkg::TOL_W-1:0] tolerance;
		logic [fmwl_pkg::ECNT_W-1:0] entry_count;
		int box_lo[3];
		int box_hi[3];
		field_result_t expected_fields[$];
		int n_errors;
		int n_loads;
		int n_queries;
		int n_hits;

		function new();
			tolerance = 112;
			entry_count = 0;
			box_lo = '{COORD_MIN, COORD_MIN, COORD_MIN};
			box_hi = '{COORD_MAX, COORD_MAX, COORD_MAX};
			n_errors = 0;
			n_loads = 0;
			n_queries = 0;
			n_hits = 0;
		endfunction

		function void set_reg(fmwl_pkg::cfg_reg_t r, logic [fmwl_pkg::CFG_DATA_W-1:0] v);
			case (r)
				fmwl_pkg::REG_TOLERANCE: tolerance = v[fmwl_pkg::TOL_W-1:0];
				fmwl_pkg::REG_ENTRY_COUNT: entry_count = v[fmwl_pkg::ECNT_W-1:0];
				fmwl_pkg::REG_BOX_MIN_X: box_lo[0] = $signed(v);
				fmwl_pkg::REG_BOX_MAX_X: box_hi[0] = $signed(v);
				fmwl_pkg::REG_BOX_MIN_Y: box_lo[1] = $signed(v);
				fmwl_pkg::REG_BOX_MAX_Y: box_hi[1] = $signed(v);
				fmwl_pkg::REG_BOX_MIN_Z: box_lo[2] = $signed(v);
				default: box_hi[2] = $signed(v);
			endcase
		endfunction

		function int axis_gap(int a, int b);
			return (a > b) ? a - b : b - a;
		endfunction

		// First entry within the window on all three axes wins; points outside the
		// box never scan the table.
		function field_result_t lookup_field(fmwl_pkg::in_data_t d);
			field_result_t res;
			int pt[3];
			int tol;
			int lim;
			int fx;
			int i;
			res = '0;
			pt[0] = d.coord_x;
			pt[1] = d.coord_y;
			pt[2] = d.coord_z;
			tol = tolerance;
			for (i = 0; i < 3; i++)
				if (pt[i] < box_lo[i] || pt[i] > box_hi[i])
					return res;
			lim = (entry_count > fmwl_pkg::TABLE_DEPTH) ? fmwl_pkg::TABLE_DEPTH : entry_count;
			for (i = 0; i < lim; i++) begin
				if (axis_gap(pt[0], pos_x[i]) < tol && axis_gap(pt[1], pos_y[i]) < tol &&
						axis_gap(pt[2], pos_z[i]) < tol) begin
					fx = fld_x[i];
					fx = -fx;
					if (fx > FIELD_MAX)
						fx = FIELD_MAX;
					res.fx = fx[fmwl_pkg::FLD_W-1:0];
					res.fy = fld_y[i];
					res.fz = fld_z[i];
					res.found = 1'b1;
					res.slot = i[fmwl_pkg::SLOT_W-1:0];
					return res;
				end
			end
			return res;
		endfunction

		function void note_input(fmwl_pkg::op_t op, fmwl_pkg::in_data_t d);
			field_result_t res;
			if (op == fmwl_pkg::OP_LOAD) begin
				pos_x[d.entry_index] = d.coord_x;
				pos_y[d.entry_index] = d.coord_y;
				pos_z[d.entry_index] = d.coord_z;
				fld_x[d.entry_index] = d.load_bx;
				fld_y[d.entry_index] = d.load_by;
				fld_z[d.entry_index] = d.load_bz;
				loaded[d.entry_index] = 1'b1;
				n_loads++;
			end else begin
				res = lookup_field(d);
				if (res.found)
					n_hits++;
				expected_fields.push_back(res);
				n_queries++;
			end
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				n_errors++;
			end
		endfunction

		function void check_result(logic [79:0] data, logic user);
			fmwl_pkg::out_data_t got;
			field_result_t want;
			got = data;
			if (expected_fields.size() == 0) begin
				$display("%0t: result with no query outstanding, expected none, actual %h/%b",
					$time, data, user);
				n_errors++;
				return;
			end
			want = expected_fields.pop_front();
			compare("field_x", want.fx, got.field_x);
			compare("field_y", want.fy, got.field_y);
			compare("field_z", want.fz, got.field_z);
			compare("match_slot", want.slot, got.match_slot);
			compare("found", want.found, user);
		endfunction

		function int pending();
			return expected_fields.size();
		endfunction

		// Number of entries loaded without a gap from slot 0; a query may scan no
		// further than this.
		function int loaded_prefix();
			int k;
			k = 0;
			while (k < fmwl_pkg::TABLE_DEPTH && loaded[k])
				k++;
			return k;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	fmwl_pkg::cfg_reg_t cfg_index = fmwl_pkg::REG_TOLERANCE;
	logic [fmwl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic m_tuser;

	field_lookup_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic rx_hold_req = 1'b0;
	logic rx_hold_seen = 1'b0;
	int rx_hold_left = 0;
	int stall_cycles = 0;
	int full_lo[3] = '{COORD_MIN, COORD_MIN, COORD_MIN};
	int full_hi[3] = '{COORD_MAX, COORD_MAX, COORD_MAX};

	field_map_window_lookup u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: check every accepted transfer, then pick tready for the next
	// edge. A hold request from the stimulus side makes this process keep tready
	// low for a long stretch, counted here, so that the block backs up.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (rx_hold_req != rx_hold_seen) begin
			rx_hold_seen <= rx_hold_req;
			rx_hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: the longest quiet stretch of a correct run is the long receiver
	// hold or one scan of the loaded entries, far below the limit.
	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Timeout after %0d cycles with no transfer", STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	function automatic fmwl_pkg::in_data_t pack_item(int idx, int x, int y, int z,
			int bx, int by, int bz);
		fmwl_pkg::in_data_t d;
		d.entry_index = idx[fmwl_pkg::SLOT_W-1:0];
		d.coord_x = x[fmwl_pkg::POS_W-1:0];
		d.coord_y = y[fmwl_pkg::POS_W-1:0];
		d.coord_z = z[fmwl_pkg::POS_W-1:0];
		d.load_bx = bx[fmwl_pkg::FLD_W-1:0];
		d.load_by = by[fmwl_pkg::FLD_W-1:0];
		d.load_bz = bz[fmwl_pkg::FLD_W-1:0];
		return d;
	endfunction

	function automatic int rand_coord();
		logic signed [fmwl_pkg::POS_W-1:0] v;
		int r;
		r = $urandom;
		v = r[fmwl_pkg::POS_W-1:0];
		return v;
	endfunction

	function automatic int rand_field();
		logic signed [fmwl_pkg::FLD_W-1:0] v;
		int r;
		r = $urandom;
		v = r[fmwl_pkg::FLD_W-1:0];
		return v;
	endfunction

	// Mostly clustered positions so that random boxes still hold entries.
	function automatic int spread_coord();
		if ($urandom_range(3) == 0)
			return rand_coord();
		return int'($urandom_range(0, 400000)) - 200000;
	endfunction

	function automatic int near_coord(int base, int span);
		int v;
		int off;
		off = $urandom_range(0, 2 * span);
		v = base + off - span;
		if (v < COORD_MIN)
			v = COORD_MIN;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	// Offers one transfer, idling beforehand at the current sender rate, and
	// leaves tvalid high so that the next item can follow without a gap.
	task automatic send_item(input fmwl_pkg::op_t op, input fmwl_pkg::in_data_t d);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(op, d);
	endtask

	task automatic send_load(input int idx, input int x, input int y, input int z,
			input int bx, input int by, input int bz);
		send_item(fmwl_pkg::OP_LOAD, pack_item(idx, x, y, z, bx, by, bz));
	endtask

	// Queries carry random junk in the fields the block ignores for them.
	task automatic send_query(input int x, input int y, input int z);
		send_item(fmwl_pkg::OP_QUERY, pack_item($urandom, x, y, z, $urandom, $urandom,
			$urandom));
	endtask

	// Stop offering and wait for every outstanding result, then let a load that
	// may still be writing the table settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input fmwl_pkg::cfg_reg_t r, input int v);
		logic [fmwl_pkg::CFG_DATA_W-1:0] w;
		w = v[fmwl_pkg::CFG_DATA_W-1:0];
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= w;
		sb.set_reg(r, w);
		@(posedge clk);
	endtask

	task automatic apply_config(input int tol, input int cnt, input int lo[3], input int hi[3]);
		wait_idle();
		put_reg(fmwl_pkg::REG_TOLERANCE, tol);
		put_reg(fmwl_pkg::REG_ENTRY_COUNT, cnt);
		put_reg(fmwl_pkg::REG_BOX_MIN_X, lo[0]);
		put_reg(fmwl_pkg::REG_BOX_MAX_X, hi[0]);
		put_reg(fmwl_pkg::REG_BOX_MIN_Y, lo[1]);
		put_reg(fmwl_pkg::REG_BOX_MAX_Y, hi[1]);
		put_reg(fmwl_pkg::REG_BOX_MIN_Z, lo[2]);
		put_reg(fmwl_pkg::REG_BOX_MAX_Z, hi[2]);
		cfg_we <= 1'b0;
	endtask

	// One random setting followed by a mix of loads, queries aimed close to a
	// loaded entry, and queries at arbitrary points.
	task automatic run_random_phase(input int n_items, input bit with_hold);
		int tol;
		int cnt;
		int prefix;
		int span;
		int sel;
		int axis;
		int k;
		int j;
		int idx;
		int lo[3];
		int hi[3];
		prefix = sb.loaded_prefix();
		sel = $urandom_range(9);
		if (sel == 0)
			tol = 0;
		else if (sel == 1)
			tol = TOL_MAX;
		else
			tol = $urandom_range(1, 3000);
		sel = $urandom_range(5);
		if (sel == 0)
			cnt = 0;
		else if (sel == 1)
			cnt = prefix;
		else
			cnt = $urandom_range(0, prefix);
		lo = full_lo;
		hi = full_hi;
		sel = $urandom_range(7);
		if (sel >= 4 && sel <= 6) begin
			for (axis = 0; axis < 3; axis++) begin
				lo[axis] = -int'($urandom_range(0, 250000));
				hi[axis] = $urandom_range(0, 250000);
			end
		end else if (sel == 7) begin
			// An inverted limit pair shuts out every point.
			axis = $urandom_range(2);
			lo[axis] = $urandom_range(1, 1000);
			hi[axis] = lo[axis] - 1;
		end
		apply_config(tol, cnt, lo, hi);
		if (with_hold)
			rx_hold_req <= ~rx_hold_req;
		span = (tol < 3000) ? tol : 3000;
		for (k = 0; k < n_items; k++) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				if ($urandom_range(9) == 0)
					idx = $urandom_range(0, fmwl_pkg::TABLE_DEPTH - 1);
				else
					idx = $urandom_range(0, (prefix < fmwl_pkg::TABLE_DEPTH) ? prefix
						: fmwl_pkg::TABLE_DEPTH - 1);
				send_load(idx, spread_coord(), spread_coord(), spread_coord(),
					rand_field(), rand_field(), rand_field());
				prefix = sb.loaded_prefix();
			end else if (sel < 80 && cnt > 0) begin
				j = $urandom_range(0, cnt - 1);
				send_query(near_coord(sb.pos_x[j], span), near_coord(sb.pos_y[j], span),
					near_coord(sb.pos_z[j], span));
			end else begin
				send_query(rand_coord(), rand_coord(), rand_coord());
			end
		end
	endtask

	initial begin
		int lo[3];
		int hi[3];
		int mode;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, sender idling 37% and receiver 61%.
		tx_idle_pct = 37;
		rx_idle_pct <= 61;
		// Reset setting scans no entries at all.
		send_query(0, 0, 0);
		send_load(0, 0, 0, 0, 100, -200, 300);
		// Most negative x field saturates when negated; slot 2 shares its position
		// and must lose to slot 1.
		send_load(1, 1000, -1000, 500, FIELD_MIN, FIELD_MAX, FIELD_MIN);
		send_load(2, 1000, -1000, 500, 5, 6, 7);
		send_load(3, COORD_MAX, COORD_MAX, COORD_MAX, FIELD_MAX, 0, -1);
		send_load(4, COORD_MIN, COORD_MIN, COORD_MIN, -1, FIELD_MIN, FIELD_MAX);
		send_load(5, 2000, 2000, 2000, 12345, -54321, 777);
		apply_config(112, 6, full_lo, full_hi);
		send_query(0, 0, 0);
		send_query(111, -111, 111);
		// A distance equal to the tolerance does not match.
		send_query(112, 0, 0);
		send_query(1000, -1000, 500);
		send_query(COORD_MAX, COORD_MAX, COORD_MAX);
		send_query(COORD_MIN, COORD_MIN, COORD_MIN);
		send_query(3000, 3000, 3000);
		// Box shrunk to a single point: on the limit is inside, one step off is not.
		lo = '{2000, 2000, 2000};
		hi = '{2000, 2000, 2000};
		apply_config(112, 6, lo, hi);
		send_query(2000, 2000, 2000);
		send_query(2001, 2000, 2000);
		lo = full_lo;
		hi = full_hi;
		lo[1] = 10;
		hi[1] = -10;
		apply_config(112, 6, lo, hi);
		send_query(0, 0, 0);
		// Zero tolerance never matches; the widest one matches far from an entry.
		apply_config(0, 6, full_lo, full_hi);
		send_query(0, 0, 0);
		apply_config(TOL_MAX, 6, full_lo, full_hi);
		send_query(300000, -300000, 0);

		// Random part in three idling modes, two settings each. The first mode
		// also holds the receiver off long enough to back the block up.
		for (mode = 0; mode < 3; mode++) begin
			if (mode == 1) begin
				tx_idle_pct = 61;
				rx_idle_pct <= 37;
			end else if (mode == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			run_random_phase(14, 1'b0);
			run_random_phase(14, mode == 0);
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		$display("Run covered %0d table loads and %0d queries, %0d of them answered by an entry,",
			sb.n_loads, sb.n_queries, sb.n_hits);
		$display("with box limits, zero and widest tolerance, saturation and a long receiver stall.");
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== field_map_window_lookup.f =====
src/fmwl_pkg.sv
src/fmwl_ram.sv
src/fmwl_ctrl.sv
src/fmwl_dp.sv
src/field_map_window_lookup.sv
test/testbench.sv
